### hw/rtl/dsp2_pkg.sv
// Package for the double scale-by-power-of-two block: widths, codes, helpers.
// No dependencies.
`default_nettype none
package dsp2_pkg;
  localparam int DataW = 64;
  localparam int ExpW  = 11;
  localparam int FracW = 52;
  localparam int KW    = 15;  // signed biased exponent after adjust

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_UP      = 2'd2,
    RM_DOWN    = 2'd3
  } rmode_t;

  localparam logic [0:0] REG_ROUNDING_MODE = 1'b0;

  localparam logic [ExpW-1:0]  EXP_ALL1    = 11'h7ff;
  localparam logic signed [KW-1:0] K_MAX   = 15'sd2046;
  // at or below this biased exponent even the smallest subnormal is lost
  localparam logic signed [KW-1:0] K_TINY  = -15'sd54;
  localparam logic [DataW-1:0] INF_BITS    = 64'h7ff0000000000000;
  localparam logic [DataW-1:0] MAX_FINITE  = 64'h7fefffffffffffff;
  localparam logic [DataW-1:0] QUIET_BIT   = 64'h0008000000000000;

  typedef struct packed {
    logic [DataW-1:0] result_bits;
    logic             overflow_flag;
    logic             underflow_flag;
    logic             inexact_flag;
    logic             invalid_flag;
  } res_t;
endpackage
`default_nettype wire

### hw/rtl/dsp2_if.sv
// Valid/ready stream interface carrying a parameterized payload type.
// Depends on nothing.
`default_nettype none
interface dsp2_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/dsp2_core.sv
// Combinational scaling datapath: classify, normalize, adjust, round.
// Depends on dsp2_pkg.
`default_nettype none
module dsp2_core
  import dsp2_pkg::*;
(
  input  wire logic [DataW-1:0] value_bits,
  input  wire logic [DataW-1:0] exponent_shift,
  input  wire logic [1:0]       rmode,
  output res_t                  res
);
  logic             neg, away, is_nan, is_inf, is_zero;
  logic [ExpW-1:0]  e;
  logic [FracW-1:0] frac, nfrac;
  logic [5:0]       lz;
  logic signed [KW-1:0] ebase, k, nclip;
  logic             n_big, n_small;
  logic [5:0]       sh;
  logic [FracW+1:0] m, q, rem, half, mask;
  logic             inx, up;

  always_comb begin
    neg  = value_bits[63];
    e    = value_bits[62:52];
    frac = value_bits[51:0];
    away = (rmode == RM_UP && !neg) || (rmode == RM_DOWN && neg);
    is_nan  = (e == EXP_ALL1) && (frac != '0);
    is_inf  = (e == EXP_ALL1) && (frac == '0);
    is_zero = (e == '0) && (frac == '0);
    // shift that moves the leading one of a subnormal fraction to the hidden bit
    lz = 6'd0;
    for (int i = 0; i < FracW; i++) begin
      if (frac[i]) lz = 6'(FracW - i);
    end
    if (e == '0) begin
      nfrac = frac << lz;
      ebase = KW'(1) - KW'(lz);
    end else begin
      nfrac = frac;
      ebase = KW'(e);
    end
    n_big   = !exponent_shift[63] && (exponent_shift > 64'd5000);
    n_small =  exponent_shift[63] && ($signed(exponent_shift) < -64'sd5000);
    nclip   = KW'($signed(exponent_shift[13:0]));
    k = n_big ? KW'(2047) : n_small ? -KW'(100) : ebase + nclip;
    // shift right by 1..54 for a subnormal result, keep the dropped bits
    m    = {1'b0, 1'b1, nfrac};
    sh   = 6'(KW'(1) - k);
    mask = {(FracW+2){1'b1}} >> (6'(FracW + 2) - sh);
    q    = m >> sh;
    rem  = m & mask;
    half = (FracW+2)'(1) << (sh - 6'd1);
    inx  = rem != '0;
    up   = inx && ((rmode == RM_NEAREST) ? (rem > half || (rem == half && q[0])) : away);
    res = '0;
    if (is_nan) begin
      res.result_bits  = value_bits | QUIET_BIT;
      res.invalid_flag = !frac[51];
    end else if (is_inf || is_zero || exponent_shift == '0) begin
      res.result_bits = value_bits;
    end else if (k > K_MAX) begin
      res.result_bits = {neg, 63'b0} |
        ((rmode == RM_NEAREST || away) ? INF_BITS : MAX_FINITE);
      res.overflow_flag = 1'b1;
      res.inexact_flag  = 1'b1;
    end else if (k <= K_TINY) begin
      res.result_bits    = {neg, 62'b0, away};
      res.underflow_flag = 1'b1;
      res.inexact_flag   = 1'b1;
    end else if (k > 0) begin
      res.result_bits = {neg, k[ExpW-1:0], nfrac};
    end else begin
      res.result_bits    = {neg, 10'b0, (FracW+1)'(q + (FracW+2)'(up))};
      res.underflow_flag = inx;
      res.inexact_flag   = inx;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/double_scale_by_power_of_two.sv
// Top level of the double scale-by-power-of-two block with APB register port.
// Depends on dsp2_pkg, dsp2_if and dsp2_core.
//
//  channel | dir | payload
//  in_     | in  | value_bits[63:0], exponent_shift[63:0]
//  out_    | out | result_bits[63:0], four flags
//  cfg_    | in  | rounding_mode at address 0
//
// An accepted beat passes the input register, which feeds the core, then the
// result register after it; one beat per cycle unless the result stage stalls.
// Both registers advance together whenever the result stage is empty or taken.
// Synchronous active-low reset clears valids and rounding mode to nearest.
`default_nettype none
module double_scale_by_power_of_two
  import dsp2_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  dsp2_if.sink              in_ch,
  dsp2_if.source            out_ch,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  logic [1:0]       rmode_r;
  logic             s1_v_r, s2_v_r;
  logic [DataW-1:0] val_r, sh_r;
  res_t             res_r, core_res;
  logic             adv;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'b0, rmode_r};

  // hold rounding mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmode_r <= RM_NEAREST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == {REG_ROUNDING_MODE, 1'b0}) begin
      rmode_r <= cfg_pwdata[1:0];
    end
  end

  assign adv         = !s2_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  dsp2_core u_core (
    .value_bits     (val_r),
    .exponent_shift (sh_r),
    .rmode          (rmode_r),
    .res            (core_res)
  );

  // advance both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= in_ch.data[127:64];
      sh_r  <= in_ch.data[63:0];
      res_r <= core_res;
    end
  end

  assign out_ch.valid = s2_v_r;
  assign out_ch.data  = res_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_ch.ready |=> s2_v_r && $stable(res_r)) else $error("result dropped");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && adv |=> s2_v_r) else $error("beat lost");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_v_r |-> in_ch.ready) else $error("stall while empty");
`endif
endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for double_scale_by_power_of_two: scalbn with APB mode register.
// Depends on dsp2_pkg, dsp2_if and the block's RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dsp2_pkg::*;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [63:0] exponent_shift;
  } operand_t;

  localparam int StallLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dsp2_if #(.payload_t(operand_t)) in_ch  (clk);
  dsp2_if #(.payload_t(res_t))     out_ch (clk);

  double_scale_by_power_of_two u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  operand_t pending_ops[$];
  res_t     scaled_q[$];
  rmode_t   cur_mode = RM_NEAREST;
  int       beats_in = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       hold_cnt = 0;
  bit       hold_done = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Scale one double by 2^n and raise the IEEE flags, under the current mode.
  function automatic res_t scale_double(operand_t op, rmode_t rm);
    res_t        r;
    logic [63:0] x;
    logic        neg;
    logic        away;
    longint      e;
    longint      n;
    longint      k;
    logic [63:0] frac;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    int          s;
    int          sh;
    x = op.value_bits;
    n = longint'(op.exponent_shift);
    neg = x[63];
    e = longint'(x[62:52]);
    frac = {12'd0, x[51:0]};
    away = (rm == RM_UP && !neg) || (rm == RM_DOWN && neg);
    r = '0;
    if (e == 2047) begin
      r.result_bits = x;
      if (frac != 0) begin
        r.result_bits = x | QUIET_BIT;
        r.invalid_flag = ~x[51];
      end
      return r;
    end
    if ((e == 0 && frac == 0) || n == 0) begin
      r.result_bits = x;
      return r;
    end
    // normalize a subnormal operand
    if (e == 0) begin
      s = 0;
      while (!frac[52] && s < 52) begin
        frac = frac << 1;
        s++;
      end
      frac[63:52] = '0;
      e = 1 - s;
    end
    if (n > 5000) k = 2047;
    else if (n < -5000) k = -100;
    else k = e + n;
    if (k > 2046) begin
      r.result_bits = {neg, 63'd0} |
                      ((rm == RM_NEAREST || away) ? INF_BITS : MAX_FINITE);
      r.overflow_flag = 1'b1;
      r.inexact_flag = 1'b1;
    end else if (k <= -54) begin
      r.result_bits = {neg, 62'd0, away};
      r.underflow_flag = 1'b1;
      r.inexact_flag = 1'b1;
    end else if (k > 0) begin
      r.result_bits = {neg, k[10:0], frac[51:0]};
    end else begin
      // denormalize and round the significand
      sh = 1 - int'(k);
      m = {11'd0, 1'b1, frac[51:0]};
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem != 0) begin
        if (rm == RM_NEAREST) begin
          if (rem > half || (rem == half && q[0])) q++;
        end else if (away) begin
          q++;
        end
        r.underflow_flag = 1'b1;
        r.inexact_flag = 1'b1;
      end
      r.result_bits = {neg, 63'd0} | q;
    end
    return r;
  endfunction

  // Drive input beats; predict each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        scaled_q.push_back(scale_double(in_ch.data, cur_mode));
        beats_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 &&
            ((beats_in >= 300 && beats_in < 400) || $urandom_range(99) >= 34)) begin
          in_ch.data <= pending_ops.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Drive ready with random gaps and one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!hold_done && beats_in >= 150) begin
      hold_done <= 1'b1;
      hold_cnt <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (beats_in >= 300 && beats_in < 400) || $urandom_range(99) >= 34;
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (scaled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_ch.data);
      end else begin
        want = scaled_q.pop_front();
        if (out_ch.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h ov%b un%b ix%b iv%b, got %h ov%b un%b ix%b iv%b",
                     want.result_bits, want.overflow_flag, want.underflow_flag,
                     want.inexact_flag, want.invalid_flag, out_ch.data.result_bits,
                     out_ch.data.overflow_flag, out_ch.data.underflow_flag,
                     out_ch.data.inexact_flag, out_ch.data.invalid_flag);
        end
      end
    end
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_mode(input logic [1:0] mode);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {REG_ROUNDING_MODE, 1'b0};
    cfg_pwdata <= {22'd0, 8'($urandom_range(255, 0)), mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cur_mode = rmode_t'(mode);
  endtask

  task automatic add_op(input logic [63:0] v, input logic [63:0] n);
    pending_ops.push_back('{value_bits: v, exponent_shift: n});
  endtask

  // Build a random operand, mostly in the interesting ranges.
  task automatic add_random_op();
    logic [63:0] v;
    logic [63:0] n;
    logic [10:0] ex;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v[62:52] = 11'd0;
      1: v[62:52] = $urandom_range(1) ? 11'h7ff : 11'h7fe;
      2: v[62:52] = 11'($urandom_range(60, 1));
      3: v[62:0] = {11'd0, 52'd1 << $urandom_range(51)};
      default: ;
    endcase
    ex = v[62:52];
    case ($urandom_range(9))
      0: n = {$urandom, $urandom};
      1: n = 64'd0;
      2: n = 64'(longint'($urandom_range(10100)) - 5050);
      3: n = 64'(-longint'(ex) - longint'($urandom_range(56)) + 1);
      4: n = 64'(2046 - longint'(ex) + longint'($urandom_range(2)) - 1);
      default: n = 64'(longint'($urandom_range(140)) - 70);
    endcase
    add_op(v, n);
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && !in_ch.valid && scaled_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(RM_NEAREST);

    // directed: specials, extremes and boundary exponents
    add_op(64'h0000000000000000, 64'd7);
    add_op(64'h8000000000000000, 64'hffffffffffffff00);
    add_op(64'h3ff0000000000000, 64'd0);
    add_op(64'h7ff0000000000000, 64'd5);
    add_op(64'hfff0000000000000, 64'h8000000000000000);
    add_op(64'h7ff8000000000001, 64'd3);
    add_op(64'h7ff0000000000001, 64'd3);
    add_op(64'hfff7ffffffffffff, 64'd0);
    add_op(64'h0000000000000001, 64'd1);
    add_op(64'h000fffffffffffff, 64'd1);
    add_op(64'h0000000000000001, 64'd1074);
    add_op(64'h7fefffffffffffff, 64'd1);
    add_op(64'hffefffffffffffff, 64'h7fffffffffffffff);
    add_op(64'h3ff0000000000000, 64'h8000000000000000);
    add_op(64'h3ff0000000000000, 64'd1023);
    add_op(64'h3ff0000000000000, 64'd1024);
    add_op(64'h3ff8000000000000, -64'sd1075);
    add_op(64'hbff8000000000000, -64'sd1074);
    add_op(64'h3ff0000000000000, -64'sd1076);
    add_op(64'h3fffffffffffffff, -64'sd1023);
    add_op(64'h0010000000000000, -64'sd1);
    add_op(64'h3ff0000000000000, 64'd5001);
    add_op(64'hbff0000000000000, -64'sd5001);
    drain();

    // random phases over every rounding mode
    for (int ph = 0; ph < 5; ph++) begin
      write_mode(ph == 4 ? 2'($urandom_range(3)) : 2'((ph + 1) % 4));
      for (int i = 0; i < 100; i++) add_random_op();
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && scaled_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
